// ===== src/row_column_hit_matcher_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the row/column hit matcher
// Concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ROW_COLUMN_HIT_MATCHER_CORE_ASSERT_SVH
`define ROW_COLUMN_HIT_MATCHER_CORE_ASSERT_SVH

// implication under clk, disabled in reset
`define RCM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the next cycle
`define RCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants of the row/column hit matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package rcm_pkg;
  localparam int ROW_SLOTS_DEF = 8;
  localparam int COL_SLOTS_DEF = 8;
  localparam int TS_W   = 8;
  localparam int TOT_W  = 12;
  localparam int LOC_W  = 6;
  localparam int FPGA_W = 48;
  localparam int ID_W   = 3;
  localparam int TSD_W  = 9;
  localparam int TOTD_W = 13;
  localparam logic [1:0] CFG_TS_MIN  = 2'd0;
  localparam logic [1:0] CFG_TS_MAX  = 2'd1;
  localparam logic [1:0] CFG_TOT_MIN = 2'd2;
  localparam logic [1:0] CFG_TOT_MAX = 2'd3;
  localparam logic signed [TSD_W-1:0]  TS_MIN_RST  = 9'sd0;
  localparam logic signed [TSD_W-1:0]  TS_MAX_RST  = 9'sd1;
  localparam logic signed [TOTD_W-1:0] TOT_MIN_RST = 13'sd6;
  localparam logic signed [TOTD_W-1:0] TOT_MAX_RST = 13'sd15;

  typedef struct packed {
    logic [ID_W-1:0]  chip;
    logic [ID_W-1:0]  layer;
    logic [TOT_W-1:0] tot;
    logic [TS_W-1:0]  ts;
    logic [LOC_W-1:0] loc;
  } row_info_t;

  typedef struct packed {
    logic [TOT_W-1:0] tot;
    logic [TS_W-1:0]  ts;
    logic [LOC_W-1:0] loc;
  } col_info_t;

  typedef struct packed {
    logic signed [TSD_W-1:0]  ts_min;
    logic signed [TSD_W-1:0]  ts_max;
    logic signed [TOTD_W-1:0] tot_min;
    logic signed [TOTD_W-1:0] tot_max;
  } win_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== src/rcm_store.sv =====
// ----------------------------------------------------------------------------
// rcm_store
// Row and column hit memories, one write port and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_store
  import rcm_pkg::*;
#(
  parameter int ROW_SLOTS = ROW_SLOTS_DEF,
  parameter int COL_SLOTS = COL_SLOTS_DEF,
  localparam int RA_W = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1,
  localparam int CA_W = (COL_SLOTS > 1) ? $clog2(COL_SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              row_we,
  input  wire logic [RA_W-1:0]   row_waddr,
  input  wire row_info_t         row_wdata,
  input  wire logic [FPGA_W-1:0] row_wfpga,
  input  wire logic              col_we,
  input  wire logic [CA_W-1:0]   col_waddr,
  input  wire col_info_t         col_wdata,
  input  wire logic [FPGA_W-1:0] col_wfpga,
  input  wire logic [RA_W-1:0]   row_raddr,
  input  wire logic [CA_W-1:0]   col_raddr,
  output row_info_t              row_rdata,
  output logic [FPGA_W-1:0]      row_rfpga,
  output col_info_t              col_rdata,
  output logic [FPGA_W-1:0]      col_rfpga
);
  row_info_t         row_mem [ROW_SLOTS];
  logic [FPGA_W-1:0] row_fmem [ROW_SLOTS];
  col_info_t         col_mem [COL_SLOTS];
  logic [FPGA_W-1:0] col_fmem [COL_SLOTS];

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr]  <= row_wdata;
      row_fmem[row_waddr] <= row_wfpga;
    end
    if (col_we) begin
      col_mem[col_waddr]  <= col_wdata;
      col_fmem[col_waddr] <= col_wfpga;
    end
    row_rdata <= row_mem[row_raddr];
    row_rfpga <= row_fmem[row_raddr];
    col_rdata <= col_mem[col_raddr];
    col_rfpga <= col_fmem[col_raddr];
  end
endmodule
`default_nettype wire

// ===== src/rcm_pair_check.sv =====
// ----------------------------------------------------------------------------
// rcm_pair_check
// Window test of one row/column pair on the registered memory outputs.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_pair_check
  import rcm_pkg::*;
(
  input  wire row_info_t row_info,
  input  wire col_info_t col_info,
  input  wire win_t      win,
  output logic           hit
);
  logic signed [TSD_W-1:0]  dts;
  logic signed [TOTD_W-1:0] dtot;

  always_comb begin
    dts  = $signed({1'b0, row_info.ts}) - $signed({1'b0, col_info.ts});
    dtot = $signed({1'b0, row_info.tot}) - $signed({1'b0, col_info.tot});
    hit  = (dts >= win.ts_min) && (dts <= win.ts_max) &&
           (dtot >= win.tot_min) && (dtot <= win.tot_max);
  end
endmodule
`default_nettype wire

// ===== src/row_column_hit_matcher_core.sv =====
// ----------------------------------------------------------------------------
// row_column_hit_matcher_core
// Groups row and column half-hits of one chip and emits matching pairs.
// ----------------------------------------------------------------------------
// Input words are taken when start is high and busy is low. A row or
// column half-hit is written to its memory. A row after a column run, or
// a flush word, closes the group: the engine then walks all stored
// pairs, one pair per cycle from the row and column memories (registered
// read). Each matching pair appears for one cycle with out_valid high;
// out_last_pair marks the final pair of the closing word. The receiver
// cannot stall. The row that closes a group is stored once the scan is
// over. Window registers are written over the cfg_ channel, always
// ready, indexes 0..3. Reset (rst_n low, synchronous) sets the default
// windows and empties the group; memories are not cleared, entries are
// read only after being written.
// ----------------------------------------------------------------------------
`default_nettype none
module row_column_hit_matcher_core
  import rcm_pkg::*;
#(
  parameter int ROW_SLOTS = ROW_SLOTS_DEF,
  parameter int COL_SLOTS = COL_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_req_type,
  input  wire logic              in_is_col,
  input  wire logic [LOC_W-1:0]  in_location,
  input  wire logic [TS_W-1:0]   in_timestamp,
  input  wire logic [TOT_W-1:0]  in_tot,
  input  wire logic [FPGA_W-1:0] in_fpga_timestamp,
  input  wire logic [ID_W-1:0]   in_layer,
  input  wire logic [ID_W-1:0]   in_chip_id,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [TOTD_W-1:0] cfg_data,
  output logic                   out_valid,
  output logic [ID_W-1:0]        out_layer,
  output logic [ID_W-1:0]        out_chip,
  output logic [LOC_W-1:0]       out_row_index,
  output logic [LOC_W-1:0]       out_col_index,
  output logic [TS_W-1:0]        out_row_stamp,
  output logic [TS_W-1:0]        out_col_stamp,
  output logic [TOT_W-1:0]       out_row_tot,
  output logic [TOT_W-1:0]       out_col_tot,
  output logic [FPGA_W-1:0]      out_row_fpga_stamp,
  output logic [FPGA_W-1:0]      out_col_fpga_stamp,
  output logic                   out_group_overflow,
  output logic                   out_last_pair
);
  localparam int RA_W = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int CA_W = (COL_SLOTS > 1) ? $clog2(COL_SLOTS) : 1;
  localparam int RC_W = $clog2(ROW_SLOTS + 1);
  localparam int CC_W = $clog2(COL_SLOTS + 1);

  state_t state_r, state_nxt;
  win_t   win_r;
  logic [RC_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CC_W-1:0] col_cnt_r, col_cnt_nxt;
  logic prev_col_r, prev_col_nxt, ovf_r, ovf_nxt;
  logic [RA_W-1:0] ri_r, ri_nxt;
  logic [CA_W-1:0] ci_r, ci_nxt;
  logic rd_vld_r, rd_vld_nxt, rd_end_r, rd_end_nxt;
  logic pend_row_r, pend_row_nxt;
  row_info_t pend_info_r, pend_info_nxt, in_row_info;
  logic [FPGA_W-1:0] pend_fpga_r, pend_fpga_nxt;
  logic held_vld_r, held_vld_nxt;
  logic accept, hit;
  logic row_we, col_we;
  logic [RA_W-1:0] row_waddr;
  row_info_t row_wdata, row_rdata;
  logic [FPGA_W-1:0] row_wfpga, row_rfpga, col_rfpga;
  col_info_t col_rdata, in_col_info;

  // held result
  row_info_t h_row_r, h_row_nxt;
  col_info_t h_col_r, h_col_nxt;
  logic [FPGA_W-1:0] h_rf_r, h_rf_nxt, h_cf_r, h_cf_nxt;
  logic h_ovf_r, h_ovf_nxt;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign in_row_info = '{chip: in_chip_id, layer: in_layer, tot: in_tot,
                         ts: in_timestamp, loc: in_location};
  assign in_col_info = '{tot: in_tot, ts: in_timestamp, loc: in_location};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{ts_min: TS_MIN_RST, ts_max: TS_MAX_RST,
                 tot_min: TOT_MIN_RST, tot_max: TOT_MAX_RST};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TS_MIN:  win_r.ts_min  <= cfg_data[TSD_W-1:0];
        CFG_TS_MAX:  win_r.ts_max  <= cfg_data[TSD_W-1:0];
        CFG_TOT_MIN: win_r.tot_min <= cfg_data;
        CFG_TOT_MAX: win_r.tot_max <= cfg_data;
        default: ;
      endcase
    end
  end

  rcm_store #(.ROW_SLOTS(ROW_SLOTS), .COL_SLOTS(COL_SLOTS)) u_store (
    .clk(clk),
    .row_we(row_we), .row_waddr(row_waddr), .row_wdata(row_wdata),
    .row_wfpga(row_wfpga),
    .col_we(col_we), .col_waddr(col_cnt_r[CA_W-1:0]), .col_wdata(in_col_info),
    .col_wfpga(in_fpga_timestamp),
    .row_raddr(ri_r), .col_raddr(ci_r),
    .row_rdata(row_rdata), .row_rfpga(row_rfpga),
    .col_rdata(col_rdata), .col_rfpga(col_rfpga)
  );

  rcm_pair_check u_check (
    .row_info(row_rdata), .col_info(col_rdata), .win(win_r), .hit(hit)
  );

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    prev_col_nxt  = prev_col_r;
    ovf_nxt       = ovf_r;
    ri_nxt        = ri_r;
    ci_nxt        = ci_r;
    rd_vld_nxt    = 1'b0;
    rd_end_nxt    = 1'b0;
    pend_row_nxt  = pend_row_r;
    pend_info_nxt = pend_info_r;
    pend_fpga_nxt = pend_fpga_r;
    held_vld_nxt  = held_vld_r;
    h_row_nxt = h_row_r; h_col_nxt = h_col_r;
    h_rf_nxt = h_rf_r; h_cf_nxt = h_cf_r; h_ovf_nxt = h_ovf_r;
    row_we    = 1'b0;
    row_waddr = row_cnt_r[RA_W-1:0];
    row_wdata = in_row_info;
    row_wfpga = in_fpga_timestamp;
    col_we    = 1'b0;
    out_valid = 1'b0;
    out_last_pair = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type || (!in_is_col && prev_col_r)) begin
            pend_row_nxt  = !in_req_type;
            pend_info_nxt = in_row_info;
            pend_fpga_nxt = in_fpga_timestamp;
            ri_nxt = '0;
            ci_nxt = '0;
            held_vld_nxt = 1'b0;
            state_nxt = ST_SCAN;
            if (row_cnt_r != '0 && col_cnt_r != '0) begin
              rd_vld_nxt = 1'b1;
              rd_end_nxt = (RC_W'(1) == row_cnt_r) && (CC_W'(1) == col_cnt_r);
              if (CC_W'(ci_r) + CC_W'(1) == col_cnt_r) begin
                ci_nxt = '0; ri_nxt = ri_r + RA_W'(1);
              end else begin
                ci_nxt = ci_r + CA_W'(1);
              end
            end else begin
              state_nxt = ST_DONE;
            end
          end else if (in_is_col) begin
            prev_col_nxt = 1'b1;
            if (col_cnt_r < CC_W'(COL_SLOTS)) begin
              col_we = 1'b1;
              col_cnt_nxt = col_cnt_r + CC_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (row_cnt_r < RC_W'(ROW_SLOTS)) begin
              row_we = 1'b1;
              row_cnt_nxt = row_cnt_r + RC_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && !rd_end_r) begin
          rd_vld_nxt = 1'b1;
          rd_end_nxt = (RC_W'(ri_r) + RC_W'(1) == row_cnt_r) &&
                       (CC_W'(ci_r) + CC_W'(1) == col_cnt_r);
          if (CC_W'(ci_r) + CC_W'(1) == col_cnt_r) begin
            ci_nxt = '0; ri_nxt = ri_r + RA_W'(1);
          end else begin
            ci_nxt = ci_r + CA_W'(1);
          end
        end
        if (rd_vld_r && hit) begin
          // release the previous hit, hold this one
          out_valid    = held_vld_r;
          held_vld_nxt = 1'b1;
          h_row_nxt = row_rdata; h_col_nxt = col_rdata;
          h_rf_nxt = row_rfpga; h_cf_nxt = col_rfpga; h_ovf_nxt = ovf_r;
        end
        if (rd_vld_r && rd_end_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid     = held_vld_r;
        out_last_pair = held_vld_r;
        held_vld_nxt  = 1'b0;
        row_cnt_nxt   = '0;
        col_cnt_nxt   = '0;
        prev_col_nxt  = 1'b0;
        ovf_nxt       = 1'b0;
        ri_nxt        = '0;
        ci_nxt        = '0;
        state_nxt     = ST_IDLE;
        if (pend_row_r) begin
          row_we       = 1'b1;
          row_waddr    = '0;
          row_wdata    = pend_info_r;
          row_wfpga    = pend_fpga_r;
          row_cnt_nxt  = RC_W'(1);
          pend_row_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      prev_col_r <= 1'b0;
      ovf_r      <= 1'b0;
      ri_r       <= '0;
      ci_r       <= '0;
      rd_vld_r   <= 1'b0;
      rd_end_r   <= 1'b0;
      pend_row_r <= 1'b0;
      held_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_cnt_r  <= row_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
      prev_col_r <= prev_col_nxt;
      ovf_r      <= ovf_nxt;
      ri_r       <= ri_nxt;
      ci_r       <= ci_nxt;
      rd_vld_r   <= rd_vld_nxt;
      rd_end_r   <= rd_end_nxt;
      pend_row_r <= pend_row_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_info_r <= pend_info_nxt;
    pend_fpga_r <= pend_fpga_nxt;
    h_row_r <= h_row_nxt;
    h_col_r <= h_col_nxt;
    h_rf_r  <= h_rf_nxt;
    h_cf_r  <= h_cf_nxt;
    h_ovf_r <= h_ovf_nxt;
  end

  assign out_layer          = h_row_r.layer;
  assign out_chip           = h_row_r.chip;
  assign out_row_index      = h_row_r.loc;
  assign out_col_index      = h_col_r.loc;
  assign out_row_stamp      = h_row_r.ts;
  assign out_col_stamp      = h_col_r.ts;
  assign out_row_tot        = h_row_r.tot;
  assign out_col_tot        = h_col_r.tot;
  assign out_row_fpga_stamp = h_rf_r;
  assign out_col_fpga_stamp = h_cf_r;
  assign out_group_overflow = h_ovf_r;

  `include "row_column_hit_matcher_core_assert.svh"

  `RCM_ASSERT_IMPL(a_last_valid, out_last_pair, out_valid, "last pair without valid")
  `RCM_ASSERT_IMPL(a_cnt_range, 1'b1,
    (row_cnt_r <= RC_W'(ROW_SLOTS)) && (col_cnt_r <= CC_W'(COL_SLOTS)), "count out of range")
  `RCM_ASSERT_NEXT(a_done_idle, state_r == ST_DONE, state_r == ST_IDLE, "done not followed by idle")
  `RCM_ASSERT_IMPL(a_out_busy, out_valid, busy, "result while idle")
endmodule
`default_nettype wire
